// ===== hdl/btp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btp_pkg;

	localparam int NUM_TYPES  = 8;
	localparam int TYPE_BITS  = 3;
	localparam int RATE_W     = 32;
	localparam int DRAW_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int SLOT_W     = 4;
	localparam int FLAG_W     = 3;
	localparam int SUM_W      = RATE_W + 2;
	localparam int PROD_W     = SUM_W + DRAW_W;

	// pair table: 2 lanes (unbind, bind), row = {a, b, prior}
	localparam int PAIR_LANES = 2;
	localparam int PAIR_ROW_W = 2 * TYPE_BITS + 1;
	localparam int PAIR_ROWS  = 1 << PAIR_ROW_W;

	// triple table: 4 lanes (bind 12, bind 23, bind 13, none), row = {a, b, c, prior}
	localparam int TRI_LANES  = 4;
	localparam int TRI_ROW_W  = 3 * TYPE_BITS + 2;
	localparam int TRI_ROWS   = 1 << TRI_ROW_W;

	typedef enum logic [1:0] {
		MODE_WR_PAIR     = 2'd0,
		MODE_WR_TRIPLE   = 2'd1,
		MODE_PAIR_STEP   = 2'd2,
		MODE_TRIPLE_STEP = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [TYPE_BITS-1:0]   index_a;
		logic [TYPE_BITS-1:0]   index_b;
		logic [TYPE_BITS-1:0]   index_c;
		logic [FLAG_W-1:0]      bound_flags;
		logic [FLAG_W-1:0]      link_flags;
		logic [DRAW_W-1:0]      draw;
		logic [SLOT_W-1:0]      rate_slot;
		logic [RATE_W-1:0]      rate_value;
	} in_item_t;

	typedef struct packed {
		logic after_12;
		logic after_23;
		logic after_13;
	} out_item_t;

	typedef struct packed {
		logic                valid;
		logic                triple;
		logic [FLAG_W-1:0]   link;
		logic [DRAW_W-1:0]   draw;
	} sel_ctrl_t;

	typedef logic [TRI_LANES-1:0][RATE_W-1:0] rate_quad_t;

endpackage

`default_nettype wire

// ===== hdl/btp_select.sv =====
`timescale 1ns / 1ps
`default_nettype none

module btp_select (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire btp_pkg::sel_ctrl_t   ctrl,
	input  wire btp_pkg::rate_quad_t  rates,
	output logic                      strobe,
	output btp_pkg::out_item_t        result
);

	logic [btp_pkg::RATE_W-1:0]  r1, r2, r3, r4;

	logic                        v_s2, trip_s2;
	logic [btp_pkg::RATE_W-1:0]  c1_s2;
	logic [btp_pkg::RATE_W:0]    c2_s2;
	logic [btp_pkg::SUM_W-1:0]   c3_s2, t_s2;
	logic [btp_pkg::DRAW_W-1:0]  draw_s2;

	logic                        v_s3, trip_s3;
	logic [btp_pkg::RATE_W-1:0]  c1_s3;
	logic [btp_pkg::RATE_W:0]    c2_s3;
	logic [btp_pkg::SUM_W-1:0]   c3_s3;
	logic [btp_pkg::PROD_W-1:0]  x_s3;

	logic                        lt1, lt2, lt3;
	logic                        strobe_q;
	btp_pkg::out_item_t          result_q;

	// mask by link flags; a pair step uses the first two lanes unmasked
	always_comb begin
		r1 = (!ctrl.triple || ctrl.link[0]) ? rates[0] : '0;
		r2 = (!ctrl.triple || ctrl.link[1]) ? rates[1] : '0;
		r3 = (ctrl.triple && ctrl.link[2]) ? rates[2] : '0;
		r4 = ctrl.triple ? rates[3] : '0;
	end

	// stage 2: cumulative rates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		trip_s2 <= ctrl.triple;
		draw_s2 <= ctrl.draw;
		c1_s2   <= r1;
		c2_s2   <= {1'b0, r1} + {1'b0, r2};
		c3_s2   <= {2'b0, r1} + {2'b0, r2} + {2'b0, r3};
		t_s2    <= {2'b0, r1} + {2'b0, r2} + {2'b0, r3} + {2'b0, r4};
	end

	// stage 3: total times draw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		trip_s3 <= trip_s2;
		c1_s3   <= c1_s2;
		c2_s3   <= c2_s2;
		c3_s3   <= c3_s2;
		x_s3    <= btp_pkg::PROD_W'(t_s2) * btp_pkg::PROD_W'(draw_s2);
	end

	// compare against cumulative rates scaled by the draw denominator
	assign lt1 = x_s3 < {2'b0, c1_s3, btp_pkg::FRAC_W'(0)};
	assign lt2 = x_s3 < {1'b0, c2_s3, btp_pkg::FRAC_W'(0)};
	assign lt3 = x_s3 < {c3_s3, btp_pkg::FRAC_W'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (trip_s3) begin
			result_q.after_12 <= lt1;
			result_q.after_23 <= !lt1 && lt2;
			result_q.after_13 <= !lt1 && !lt2 && lt3;
		end else begin
			result_q.after_12 <= !lt1;
			result_q.after_23 <= 1'b0;
			result_q.after_13 <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hdl/binding_transition_picker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A step item passes the read register, select stages 2 and 3 and the output register.
// Throughput: one item per cycle unless busy; each step reads all table lanes in parallel.
// Write items give no result and update the tables at the accept edge.
// Reset: both tables are swept to zero, one triple row and one pair row a cycle, over all
// 2048 triple rows; busy stays high during the sweep. The receiver cannot stall results.
module binding_transition_picker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire btp_pkg::in_item_t   item,
	output logic                     strobe,
	output btp_pkg::out_item_t       result
);

	// lane memories: the pair table splits into unbind/bind lanes, the triple
	// table into its four rates per prior bond, so one row read gives a full step
	logic [btp_pkg::RATE_W-1:0] pair_mem_q [btp_pkg::PAIR_LANES][btp_pkg::PAIR_ROWS];
	logic [btp_pkg::RATE_W-1:0] tri_mem_q  [btp_pkg::TRI_LANES][btp_pkg::TRI_ROWS];

	logic                          clearing_q;
	logic [btp_pkg::TRI_ROW_W-1:0] clr_cnt_q;

	logic                          accept;
	logic                          step_acc;

	logic [btp_pkg::PAIR_LANES-1:0]  pair_we;
	logic [btp_pkg::PAIR_ROW_W-1:0]  pair_waddr, pair_raddr;
	logic [btp_pkg::TRI_LANES-1:0]   tri_we;
	logic [btp_pkg::TRI_ROW_W-1:0]   tri_waddr, tri_raddr;
	logic [btp_pkg::RATE_W-1:0]      wdata;
	logic [1:0]                      prior_row;

	logic [btp_pkg::RATE_W-1:0]      pair_rd_s1 [btp_pkg::PAIR_LANES];
	logic [btp_pkg::RATE_W-1:0]      tri_rd_s1  [btp_pkg::TRI_LANES];
	btp_pkg::sel_ctrl_t              ctrl_s1;
	btp_pkg::rate_quad_t             rates;

	assign busy     = clearing_q;
	assign accept   = start && !busy;
	assign step_acc = accept && (item.mode == btp_pkg::MODE_PAIR_STEP
		|| item.mode == btp_pkg::MODE_TRIPLE_STEP);

	// sweep both tables to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// prior bond row for a triple step: 12, then 23, then 13, else none
	always_comb begin
		if (item.bound_flags[0]) begin
			prior_row = 2'd0;
		end else if (item.bound_flags[1]) begin
			prior_row = 2'd1;
		end else if (item.bound_flags[2]) begin
			prior_row = 2'd2;
		end else begin
			prior_row = 2'd3;
		end
	end

	assign pair_raddr = {item.index_a, item.index_b, item.bound_flags[0]};
	assign tri_raddr  = {item.index_a, item.index_b, item.index_c, prior_row};

	// write port: sweep address while clearing, else the write item's lane and row
	always_comb begin
		pair_we = '0;
		tri_we  = '0;
		if (clearing_q) begin
			pair_we    = '1;
			tri_we     = '1;
			pair_waddr = clr_cnt_q[btp_pkg::PAIR_ROW_W-1:0];
			tri_waddr  = clr_cnt_q;
			wdata      = '0;
		end else begin
			pair_waddr = {item.index_a, item.index_b, item.rate_slot[1]};
			tri_waddr  = {item.index_a, item.index_b, item.index_c, item.rate_slot[3:2]};
			wdata      = item.rate_value;
			// drop pair writes to slots above the four that exist
			if (accept && item.mode == btp_pkg::MODE_WR_PAIR && item.rate_slot[3:2] == 2'b00) begin
				pair_we[item.rate_slot[0]] = 1'b1;
			end
			if (accept && item.mode == btp_pkg::MODE_WR_TRIPLE) begin
				tri_we[item.rate_slot[1:0]] = 1'b1;
			end
		end
	end

	// writes land at their accept edge and each item reads at its own, so a step
	// right behind a write already sees it; no forwarding is needed
	for (genvar k = 0; k < btp_pkg::PAIR_LANES; k++) begin : g_pair
		always_ff @(posedge clk) begin
			if (pair_we[k]) begin
				pair_mem_q[k][pair_waddr] <= wdata;
			end
			pair_rd_s1[k] <= pair_mem_q[k][pair_raddr];
		end
	end

	for (genvar k = 0; k < btp_pkg::TRI_LANES; k++) begin : g_tri
		always_ff @(posedge clk) begin
			if (tri_we[k]) begin
				tri_mem_q[k][tri_waddr] <= wdata;
			end
			tri_rd_s1[k] <= tri_mem_q[k][tri_raddr];
		end
	end

	// hold the step's control alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid  <= step_acc;
			ctrl_s1.triple <= item.mode == btp_pkg::MODE_TRIPLE_STEP;
			ctrl_s1.link   <= item.link_flags;
			ctrl_s1.draw   <= item.draw;
		end
	end

	// steer the table that the step used onto the four rate lanes
	always_comb begin
		if (ctrl_s1.triple) begin
			rates[0] = tri_rd_s1[0];
			rates[1] = tri_rd_s1[1];
			rates[2] = tri_rd_s1[2];
			rates[3] = tri_rd_s1[3];
		end else begin
			rates[0] = pair_rd_s1[0];
			rates[1] = pair_rd_s1[1];
			rates[2] = '0;
			rates[3] = '0;
		end
	end

	btp_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_s1),
		.rates  (rates),
		.strobe (strobe),
		.result (result)
	);

	// every accepted step gives exactly one result strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe == $past(step_acc, 4))
		else $error("result strobe does not follow an accepted step");

	// at most one bond is formed by a step
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $onehot0({result.after_12, result.after_23, result.after_13}))
		else $error("more than one bond in a result");

	// the sweep ends only after the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (&$past(clr_cnt_q)))
		else $error("clearing sweep ended early");

endmodule

`default_nettype wire

// ===== bench/binding_transition_picker_test.sv =====
`timescale 1ns / 1ps

module binding_transition_picker_test;
	import btp_pkg::*;

	// Table sizes as the block addresses them: {a, b, slot} and {a, b, c, slot}.
	// Types are three bits wide, so every index is in range for NUM_TYPES = 8.
	localparam int PAIR_ENTRIES   = NUM_TYPES * NUM_TYPES * 4;
	localparam int TRIPLE_ENTRIES = NUM_TYPES * NUM_TYPES * NUM_TYPES * 16;

	// About 1150 counted items; pair writes to slots above 3 are dropped by the
	// block and do not count.
	localparam int RANDOM_ITEMS = 1150;
	// The tail of the run goes without sender gaps.
	localparam int CALM_TAIL    = 150;
	// Cycles to wait once nothing is outstanding.
	localparam int DRAIN_CYCLES = 16;
	// The slowest quiet stretch is the clearing sweep after reset plus the reset
	// itself, one sender gap and the pipeline; take that several times.
	localparam int WATCHDOG_LIMIT = 10000;
	// Print at most this many mismatch lines; the rest are only counted.
	localparam int REPORT_LINES   = 40;

	localparam logic [RATE_W-1:0] RATE_ONE = 32'h0001_0000;   // 1.0 in Q16.16
	localparam logic [RATE_W-1:0] RATE_TOP = 32'hFFFF_FFFF;

	// Outcomes as they appear on the result port.
	localparam out_item_t PAIR_BOUND = '{1'b1, 1'b0, 1'b0};
	localparam out_item_t PAIR_FREE  = '{1'b0, 1'b0, 1'b0};
	localparam out_item_t BOND_12    = '{1'b1, 1'b0, 1'b0};
	localparam out_item_t BOND_23    = '{1'b0, 1'b1, 1'b0};
	localparam out_item_t BOND_13    = '{1'b0, 1'b0, 1'b1};
	localparam out_item_t NO_BOND    = '{1'b0, 1'b0, 1'b0};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      strobe;
	out_item_t result;

	// Sideband travelling with each item: a hand-written outcome for the
	// directed rows that can be read off at a glance.
	logic      typed_pending;
	out_item_t typed_result;

	// Own copy of both rate tables; two-state, so they start cleared like the block.
	bit [RATE_W-1:0] pair_rate_mem   [PAIR_ENTRIES];
	bit [RATE_W-1:0] triple_rate_mem [TRIPLE_ENTRIES];

	out_item_t outcome_q [$];
	out_item_t want;
	out_item_t forecast;
	bit        gives;

	int mismatches   = 0;
	int quiet_cycles = 0;
	int gap_odds     = 4;
	int n_pair_wr    = 0;
	int n_tri_wr     = 0;
	int n_pair_step  = 0;
	int n_tri_step   = 0;
	int n_bound      = 0;
	int n_pick [4]   = '{0, 0, 0, 0};

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} script_row_t;

	localparam int SCRIPT_LEN = 25;

	// Directed opening. Field order: mode, a, b, c, bound, link, draw, slot, value.
	// Rows with typed set carry an outcome worked out by hand; the rest are
	// checked against the predictor.
	script_row_t script [SCRIPT_LEN] = '{
		// empty tables: a pair step answers bound, a triple step answers none
		'{'{MODE_PAIR_STEP,   3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd0, 32'h0}, 1'b1, PAIR_BOUND},
		'{'{MODE_PAIR_STEP,   3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 16'hFFFF, 4'd15, RATE_TOP}, 1'b1, PAIR_BOUND},
		'{'{MODE_TRIPLE_STEP, 3'd0, 3'd0, 3'd0, 3'd0, 3'd7, 16'h0000, 4'd0, 32'h0}, 1'b1, NO_BOND},
		'{'{MODE_TRIPLE_STEP, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 16'hFFFF, 4'd15, RATE_TOP}, 1'b1, NO_BOND},
		// pair (1,2) free state: unbind 1.0, bind 1.0, so the split sits at half
		'{'{MODE_WR_PAIR,     3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd0, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_WR_PAIR,     3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd1, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_PAIR_STEP,   3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd0, 32'h0}, 1'b1, PAIR_FREE},
		'{'{MODE_PAIR_STEP,   3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h8000, 4'd0, 32'h0}, 1'b1, PAIR_BOUND},
		// pair write to a slot above 3 must leave the bind rate alone
		'{'{MODE_WR_PAIR,     3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd9, RATE_TOP}, 1'b0, NO_BOND},
		'{'{MODE_PAIR_STEP,   3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 16'h7FFF, 4'd0, 32'h0}, 1'b1, PAIR_FREE},
		// largest rates in the bound state of (7,7)
		'{'{MODE_WR_PAIR,     3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd2, RATE_TOP}, 1'b0, NO_BOND},
		'{'{MODE_WR_PAIR,     3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 16'h0000, 4'd3, RATE_TOP}, 1'b0, NO_BOND},
		'{'{MODE_PAIR_STEP,   3'd7, 3'd7, 3'd0, 3'd1, 3'd0, 16'hFFFF, 4'd0, 32'h0}, 1'b0, NO_BOND},
		// triple (2,3,4) with no prior bond: four equal rates of 1.0
		'{'{MODE_WR_TRIPLE,   3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 16'h0000, 4'd12, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_WR_TRIPLE,   3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 16'h0000, 4'd13, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_WR_TRIPLE,   3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 16'h0000, 4'd14, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_WR_TRIPLE,   3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 16'h0000, 4'd15, RATE_ONE}, 1'b0, NO_BOND},
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 16'h0000, 4'd0, 32'h0}, 1'b1, BOND_12},
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 16'h4000, 4'd0, 32'h0}, 1'b1, BOND_23},
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 16'h8000, 4'd0, 32'h0}, 1'b1, BOND_13},
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 16'hC000, 4'd0, 32'h0}, 1'b1, NO_BOND},
		// all links closed leaves only the no-bond rate; link 23 alone wins at zero
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 16'h0000, 4'd0, 32'h0}, 1'b1, NO_BOND},
		'{'{MODE_TRIPLE_STEP, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2, 16'h0000, 4'd0, 32'h0}, 1'b1, BOND_23},
		// prior bond 13 row of (7,7,7): only the largest bind-13 rate is set
		'{'{MODE_WR_TRIPLE,   3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 16'h0000, 4'd10, RATE_TOP}, 1'b0, NO_BOND},
		'{'{MODE_TRIPLE_STEP, 3'd7, 3'd7, 3'd7, 3'd4, 3'd4, 16'hFFFF, 4'd0, 32'h0}, 1'b1, BOND_13}
	};

	binding_transition_picker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predict the outcome of one accepted item and apply any table write.
	function automatic void pick_transition(input in_item_t it, output bit gives_result,
			output out_item_t outcome);
		logic [63:0] r [4];
		logic [63:0] total;
		logic [63:0] x;
		logic [1:0]  row;
		outcome = '0;
		gives_result = 1'b0;
		case (it.mode)
			MODE_WR_PAIR: begin
				// the pair table only has four columns; drop anything beyond
				if (it.rate_slot < 4)
					pair_rate_mem[{it.index_a, it.index_b, it.rate_slot[1:0]}] = it.rate_value;
			end
			MODE_WR_TRIPLE: begin
				triple_rate_mem[{it.index_a, it.index_b, it.index_c, it.rate_slot}] =
					it.rate_value;
			end
			MODE_PAIR_STEP: begin
				// unbind and bind rates of the prior state; stay free only when
				// the draw lands inside the unbind share
				r[0] = 64'(pair_rate_mem[{it.index_a, it.index_b, it.bound_flags[0], 1'b0}]);
				r[1] = 64'(pair_rate_mem[{it.index_a, it.index_b, it.bound_flags[0], 1'b1}]);
				x = (r[0] + r[1]) * 64'(it.draw);
				outcome.after_12 = !(x < (r[0] << 16));
				gives_result = 1'b1;
			end
			MODE_TRIPLE_STEP: begin
				// prior bond by priority: 12, then 23, then 13, else none
				if (it.bound_flags[0])
					row = 2'd0;
				else if (it.bound_flags[1])
					row = 2'd1;
				else if (it.bound_flags[2])
					row = 2'd2;
				else
					row = 2'd3;
				for (int k = 0; k < 4; k++)
					r[k] = 64'(triple_rate_mem[{it.index_a, it.index_b, it.index_c, row,
						2'(k)}]);
				// closed links carry no rate; the no-bond rate is never masked
				for (int k = 0; k < 3; k++)
					if (!it.link_flags[k])
						r[k] = '0;
				total = r[0] + r[1] + r[2] + r[3];
				x = total * 64'(it.draw);
				if (x < (r[0] << 16))
					outcome = BOND_12;
				else if (x < ((r[0] + r[1]) << 16))
					outcome = BOND_23;
				else if (x < ((r[0] + r[1] + r[2]) << 16))
					outcome = BOND_13;
				else
					outcome = NO_BOND;
				gives_result = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Mostly a small pool of types so writes and steps meet; now and then any type.
	function automatic logic [TYPE_BITS-1:0] pick_type();
		if ($urandom_range(0, 3) != 0)
			return TYPE_BITS'($urandom_range(0, 1));
		return TYPE_BITS'($urandom_range(0, NUM_TYPES - 1));
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			it.mode = MODE_WR_PAIR;
		else if (roll < 6)
			it.mode = MODE_WR_TRIPLE;
		else if (roll < 8)
			it.mode = MODE_PAIR_STEP;
		else
			it.mode = MODE_TRIPLE_STEP;
		it.index_a     = pick_type();
		it.index_b     = pick_type();
		it.index_c     = pick_type();
		it.bound_flags = FLAG_W'($urandom_range(0, 7));
		it.link_flags  = FLAG_W'($urandom_range(0, 7));
		it.draw        = DRAW_W'($urandom());
		// pair writes mostly hit a real column, sometimes one the block drops
		if (it.mode == MODE_WR_PAIR && $urandom_range(0, 7) != 0)
			it.rate_slot = SLOT_W'($urandom_range(0, 3));
		else
			it.rate_slot = SLOT_W'($urandom_range(0, 15));
		// rates of like size give split outcomes; mix in zero, the top and any value
		case ($urandom_range(0, 7))
			0: it.rate_value = '0;
			1: it.rate_value = RATE_TOP;
			2, 3, 4: it.rate_value = RATE_W'($urandom_range(0, 32'h0004_0000));
			default: it.rate_value = $urandom();
		endcase
		return it;
	endfunction

	// Offer one item, after a random gap when idling is on, and hold it until taken.
	task automatic send_item(input in_item_t stim, input bit typed, input out_item_t typed_want);
		int gap;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			gap = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		item          <= stim;
		typed_pending <= typed;
		typed_result  <= typed_want;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// Check results against the oldest outcome, then log any item taken at this
	// edge. A result always trails the edge that took its item, so the order is safe.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (outcome_q.size() == 0) begin
				report_mismatch($sformatf("result %b with no step outstanding", result));
			end else begin
				want = outcome_q.pop_front();
				if (result.after_12 !== want.after_12)
					report_mismatch($sformatf("after_12 %b, expected %b",
						result.after_12, want.after_12));
				if (result.after_23 !== want.after_23)
					report_mismatch($sformatf("after_23 %b, expected %b",
						result.after_23, want.after_23));
				if (result.after_13 !== want.after_13)
					report_mismatch($sformatf("after_13 %b, expected %b",
						result.after_13, want.after_13));
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			pick_transition(item, gives, forecast);
			if (gives)
				outcome_q.push_back(typed_pending ? typed_result : forecast);
			case (item.mode)
				MODE_WR_PAIR:   n_pair_wr++;
				MODE_WR_TRIPLE: n_tri_wr++;
				MODE_PAIR_STEP: begin
					n_pair_step++;
					if (forecast.after_12)
						n_bound++;
				end
				MODE_TRIPLE_STEP: begin
					n_tri_step++;
					n_pick[{forecast.after_23 | forecast.after_13, forecast.after_13 |
						(forecast == NO_BOND)}]++;
				end
				default: ;
			endcase
		end
		if ((start && busy === 1'b0) || strobe === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Give up when nothing has moved for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int n;
		in_item_t next;
		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		typed_pending = 1'b0;
		typed_result  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; the first item waits out the clearing sweep.
		foreach (script[i])
			send_item(script[i].stim, script[i].typed, script[i].want);

		// Random part: stretches with and without gaps, and a calm tail.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n % 64 == 0)
				gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			if (n >= RANDOM_ITEMS - CALM_TAIL)
				gap_odds = 0;
			next = random_item();
			send_item(next, 1'b0, NO_BOND);
			if (!(next.mode == MODE_WR_PAIR && next.rate_slot > 3))
				n++;
		end
		start <= 1'b0;

		// Drain, then allow for a stray late result.
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pair steps (%0d bound) and %0d triple steps",
			n_pair_step, n_bound, n_tri_step);
		$display("over %0d pair and %0d triple writes", n_pair_wr, n_tri_wr);
		$display("triple picks: bond 12 %0d, bond 23 %0d, bond 13 %0d, none %0d; %0d mismatches",
			n_pick[0], n_pick[2], n_pick[3], n_pick[1], mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
